// ===== rtl/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, token kinds and keyword table for the script source lexer.
// ----------------------------------------------------------------------------
package ssl_pkg;

    // Width of the running byte offset (wraps at this width).
    localparam int OFFSET_BITS = 24;
    // Reported widths of start offset and token length.
    localparam int START_BITS  = 24;
    localparam int LEN_BITS    = 24;
    localparam int VALUE_BITS  = 32;
    localparam int KIND_BITS   = 6;
    localparam int PREFIX_LEN  = 5;
    localparam int PREFIX_BITS = 8 * PREFIX_LEN;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_ID      = 6'd0;
    localparam logic [KIND_BITS-1:0] K_NUM     = 6'd1;
    localparam logic [KIND_BITS-1:0] K_BOOL    = 6'd2;
    localparam logic [KIND_BITS-1:0] K_LET     = 6'd3;
    localparam logic [KIND_BITS-1:0] K_CONST   = 6'd4;
    localparam logic [KIND_BITS-1:0] K_IF      = 6'd5;
    localparam logic [KIND_BITS-1:0] K_ELSE    = 6'd6;
    localparam logic [KIND_BITS-1:0] K_ELIF    = 6'd7;
    localparam logic [KIND_BITS-1:0] K_WHILE   = 6'd8;
    localparam logic [KIND_BITS-1:0] K_FUNC    = 6'd9;
    localparam logic [KIND_BITS-1:0] K_ARROW   = 6'd10;
    localparam logic [KIND_BITS-1:0] K_OUTN    = 6'd11;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd12;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd13;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd14;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd15;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd16;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd17;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd18;
    localparam logic [KIND_BITS-1:0] K_STAR    = 6'd19;
    localparam logic [KIND_BITS-1:0] K_DIV     = 6'd20;
    localparam logic [KIND_BITS-1:0] K_PERCENT = 6'd21;
    localparam logic [KIND_BITS-1:0] K_GT      = 6'd22;
    localparam logic [KIND_BITS-1:0] K_GE      = 6'd23;
    localparam logic [KIND_BITS-1:0] K_EQEQ    = 6'd24;
    localparam logic [KIND_BITS-1:0] K_LE      = 6'd25;
    localparam logic [KIND_BITS-1:0] K_LT      = 6'd26;
    localparam logic [KIND_BITS-1:0] K_NE      = 6'd27;
    localparam logic [KIND_BITS-1:0] K_AND     = 6'd28;
    localparam logic [KIND_BITS-1:0] K_OR      = 6'd29;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd30;
    localparam logic [KIND_BITS-1:0] K_BANG    = 6'd31;
    localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd32;
    localparam logic [KIND_BITS-1:0] K_EOF     = 6'd33;
    localparam logic [KIND_BITS-1:0] K_ERR     = 6'd34;

    // Scanner modes
    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_NUM     = 12'b0000_0000_0010,
        M_IDENT   = 12'b0000_0000_0100,
        M_BANG    = 12'b0000_0000_1000,
        M_EQ      = 12'b0000_0001_0000,
        M_LT      = 12'b0000_0010_0000,
        M_GT      = 12'b0000_0100_0000,
        M_AMP     = 12'b0000_1000_0000,
        M_BAR     = 12'b0001_0000_0000,
        M_SLASH   = 12'b0010_0000_0000,
        M_COMMENT = 12'b0100_0000_0000,
        M_ERROR   = 12'b1000_0000_0000
    } t_mode;

    typedef struct packed {
        logic                   last;
        logic [LEN_BITS-1:0]    len;
        logic [START_BITS-1:0]  start;
        logic [VALUE_BITS-1:0]  value;
        logic [KIND_BITS-1:0]   kind;
    } t_token;

    // Tokens produced by one transaction, in order
    typedef struct packed {
        logic [1:0] count;
        t_token     tok1;
        t_token     tok0;
    } t_scan;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [VALUE_BITS-1:0] value;
    } t_kw;

    // Keyword match on the packed identifier prefix (first byte highest).
    function automatic t_kw kw_lookup(input logic [PREFIX_BITS-1:0] prefix);
        t_kw kw;
        kw = '{kind: K_ID, value: '0};
        case (prefix)
            40'h00_0076_6172: kw.kind = K_LET;      // var
            40'h63_6f6e_7374: kw.kind = K_CONST;    // const
            40'h00_0000_6966: kw.kind = K_IF;       // if
            40'h00_656c_6966: kw.kind = K_ELIF;     // elif
            40'h00_656c_7365: kw.kind = K_ELSE;     // else
            40'h77_6869_6c65: kw.kind = K_WHILE;    // while
            40'h00_6675_6e63: kw.kind = K_FUNC;     // func
            40'h00_6f75_746e: kw.kind = K_OUTN;     // outn
            40'h00_7472_7565: begin                 // true
                kw.kind  = K_BOOL;
                kw.value = VALUE_BITS'(1);
            end
            40'h66_616c_7365: kw.kind = K_BOOL;     // false
            default: kw.kind = K_ID;
        endcase
        return kw;
    endfunction

endpackage

// ===== rtl/ssl_scanner.sv =====
// ----------------------------------------------------------------------------
// ssl_scanner
// Scanner state and single-pass next-state/token logic for one byte.
// ----------------------------------------------------------------------------
module ssl_scanner (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_cmd,
    input  logic [7:0]             i_byte,
    output ssl_pkg::t_scan         o_scan
);
    import ssl_pkg::*;

    t_mode                   r_mode, n_mode;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic [PREFIX_BITS-1:0]  r_prefix, n_prefix;
    logic                    r_too_long, n_too_long;
    logic [OFFSET_BITS-1:0]  r_start, n_start;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [LEN_BITS-1:0]     r_len, n_len;

    logic       is_end, is_digit, is_alpha, is_space;
    logic       pend_v, b_emit, do_begin, a_v, b_v;
    t_mode      b_mode;
    t_token     pend_tok, b_tok, tok_a, tok_b, eof_tok;
    t_kw        kw;
    logic [LEN_BITS-1:0] len_inc;

    assign is_end   = (i_cmd == CMD_END) || (i_byte == 8'h00);
    assign is_digit = (i_byte >= "0") && (i_byte <= "9");
    assign is_alpha = (i_byte == "_") || ((i_byte >= "a") && (i_byte <= "z"))
                      || ((i_byte >= "A") && (i_byte <= "Z"));
    assign is_space = (i_byte == " ") || ((i_byte >= 8'd9) && (i_byte <= 8'd13));
    assign len_inc  = (r_len != LEN_MAX) ? r_len + LEN_BITS'(1) : r_len;
    assign kw       = kw_lookup(r_prefix);

    // Token that the pending mode closes with when the next byte cannot extend it
    always_comb begin
        pend_v         = 1'b1;
        pend_tok       = '0;
        pend_tok.start = START_BITS'(r_start);
        pend_tok.len   = LEN_BITS'(1);
        unique case (r_mode)
            M_NUM: begin
                pend_tok.kind  = K_NUM;
                pend_tok.value = r_acc;
                pend_tok.len   = r_len;
            end
            M_IDENT: begin
                pend_tok.len = r_len;
                if (!r_too_long) begin
                    pend_tok.kind  = kw.kind;
                    pend_tok.value = kw.value;
                end else begin
                    pend_tok.kind = K_ID;
                end
            end
            M_BANG:  pend_tok.kind = K_BANG;
            M_EQ:    pend_tok.kind = K_ASSIGN;
            M_LT:    pend_tok.kind = K_LT;
            M_GT:    pend_tok.kind = K_GT;
            M_AMP: begin
                pend_tok.kind  = K_ERR;
                pend_tok.value = VALUE_BITS'("&");
            end
            M_BAR: begin
                pend_tok.kind  = K_ERR;
                pend_tok.value = VALUE_BITS'("|");
            end
            M_SLASH: pend_tok.kind = K_DIV;
            default: pend_v = 1'b0;
        endcase
    end

    // Classification of a byte that starts a new token
    always_comb begin
        b_mode      = M_IDLE;
        b_emit      = 1'b0;
        b_tok       = '0;
        b_tok.start = START_BITS'(r_offset);
        b_tok.len   = LEN_BITS'(1);
        if (is_space) begin
            b_mode = M_IDLE;
        end else if (is_digit) begin
            b_mode = M_NUM;
        end else if (is_alpha) begin
            b_mode = M_IDENT;
        end else begin
            unique case (i_byte)
                "(": begin b_emit = 1'b1; b_tok.kind = K_LPAREN;  end
                ")": begin b_emit = 1'b1; b_tok.kind = K_RPAREN;  end
                "{": begin b_emit = 1'b1; b_tok.kind = K_LBRACE;  end
                "}": begin b_emit = 1'b1; b_tok.kind = K_RBRACE;  end
                ";": begin b_emit = 1'b1; b_tok.kind = K_SEMI;    end
                ",": begin b_emit = 1'b1; b_tok.kind = K_COMMA;   end
                "+": begin b_emit = 1'b1; b_tok.kind = K_PLUS;    end
                "-": begin b_emit = 1'b1; b_tok.kind = K_MINUS;   end
                "*": begin b_emit = 1'b1; b_tok.kind = K_STAR;    end
                "%": begin b_emit = 1'b1; b_tok.kind = K_PERCENT; end
                "!": b_mode = M_BANG;
                "=": b_mode = M_EQ;
                "<": b_mode = M_LT;
                ">": b_mode = M_GT;
                "&": b_mode = M_AMP;
                "|": b_mode = M_BAR;
                "/": b_mode = M_SLASH;
                default: begin
                    b_emit      = 1'b1;
                    b_tok.kind  = K_ERR;
                    b_tok.value = VALUE_BITS'(i_byte);
                    b_mode      = M_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_prefix   = r_prefix;
        n_too_long = r_too_long;
        n_start    = r_start;
        n_offset   = r_offset + OFFSET_BITS'(1);
        n_len      = r_len;
        do_begin   = 1'b0;
        a_v        = 1'b0;
        b_v        = 1'b0;
        tok_a      = pend_tok;
        tok_b      = b_tok;

        eof_tok       = '0;
        eof_tok.kind  = K_EOF;
        eof_tok.start = START_BITS'(r_offset);

        if (is_end) begin
            a_v        = pend_v;
            b_v        = 1'b1;
            tok_b      = eof_tok;
            n_mode     = M_IDLE;
            n_acc      = '0;
            n_prefix   = '0;
            n_too_long = 1'b0;
            n_start    = '0;
            n_offset   = '0;
            n_len      = '0;
        end else begin
            unique case (r_mode)
                M_NUM: begin
                    if (is_digit) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(i_byte[3:0]);
                        n_len = len_inc;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha || is_digit) begin
                        if (r_len < LEN_BITS'(PREFIX_LEN)) begin
                            n_prefix = {r_prefix[PREFIX_BITS-9:0], i_byte};
                        end else begin
                            n_too_long = 1'b1;
                        end
                        n_len = len_inc;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_BANG, M_LT, M_GT: begin
                    if (i_byte == "=") begin
                        a_v       = 1'b1;
                        tok_a.len = LEN_BITS'(2);
                        tok_a.kind = (r_mode == M_BANG) ? K_NE :
                                     (r_mode == M_LT) ? K_LE : K_GE;
                        n_mode    = M_IDLE;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_EQ: begin
                    if ((i_byte == "=") || (i_byte == ">")) begin
                        a_v        = 1'b1;
                        tok_a.len  = LEN_BITS'(2);
                        tok_a.kind = (i_byte == "=") ? K_EQEQ : K_ARROW;
                        n_mode     = M_IDLE;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_AMP, M_BAR: begin
                    a_v = 1'b1;
                    if (i_byte == ((r_mode == M_AMP) ? 8'("&") : 8'("|"))) begin
                        tok_a.len   = LEN_BITS'(2);
                        tok_a.kind  = (r_mode == M_AMP) ? K_AND : K_OR;
                        tok_a.value = '0;
                        n_mode      = M_IDLE;
                    end else begin
                        // lone & or |: error for it, this byte is swallowed
                        n_mode = M_ERROR;
                    end
                end
                M_SLASH: begin
                    if (i_byte == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_byte == 8'h0a) begin
                        n_mode = M_IDLE;
                    end
                end
                M_ERROR: n_mode = M_ERROR;
                default: do_begin = 1'b1;
            endcase

            if (do_begin) begin
                a_v     = pend_v;
                b_v     = b_emit;
                n_mode  = b_mode;
                n_start = r_offset;
                n_len   = LEN_BITS'(1);
                if (is_digit) begin
                    n_acc = VALUE_BITS'(i_byte[3:0]);
                end
                if (is_alpha) begin
                    n_prefix   = PREFIX_BITS'(i_byte);
                    n_too_long = 1'b0;
                end
            end
        end
    end

    // Pack the produced tokens in order and flag the final one
    always_comb begin
        o_scan = '0;
        if (a_v) begin
            o_scan.tok0  = tok_a;
            o_scan.tok1  = tok_b;
            o_scan.count = b_v ? 2'd2 : 2'd1;
        end else begin
            o_scan.tok0  = tok_b;
            o_scan.count = b_v ? 2'd1 : 2'd0;
        end
        if (o_scan.count == 2'd2) begin
            o_scan.tok1.last = 1'b1;
        end else begin
            o_scan.tok0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_acc      <= '0;
            r_prefix   <= '0;
            r_too_long <= 1'b0;
            r_start    <= '0;
            r_offset   <= '0;
            r_len      <= '0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_acc      <= n_acc;
            r_prefix   <= n_prefix;
            r_too_long <= n_too_long;
            r_start    <= n_start;
            r_offset   <= n_offset;
            r_len      <= n_len;
        end
    end

endmodule

// ===== rtl/script_source_lexer.sv =====
// ----------------------------------------------------------------------------
// script_source_lexer
// Byte-stream tokenizer for a small scripting language.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transaction per source byte (tuser = 0, tdata = byte)
//   or an end of source (tuser = 1). A zero byte also ends the source.
//   Master channel: one transaction per token; tuser = token kind, tdata =
//   {length, start offset, value}, tlast marks the final token caused by an
//   input transaction. End of source flushes the pending token, sends EOF and
//   restarts offsets at zero.
// Output: a token is registered into the output buffer when the byte that
//   completes it is scanned from the input register.
// Throughput: one byte per cycle while the master side accepts and each byte
//   gives at most one token; after a two-token byte the next byte waits while
//   the two-entry token output buffer drains one token per cycle.
// Reset: synchronous, active low; clears the scanner and empties both
//   buffers. A stalled master side holds its token; the input register keeps
//   taking one byte, after which tready drops until the buffer frees.
// ----------------------------------------------------------------------------
module script_source_lexer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] source_byte
    input  logic         i_s_axis_tuser,   // [0] cmd
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [79:0]  o_m_axis_tdata,   // [31:0] token_value, [55:32] start_offset,
                                           // [79:56] token_length
    output logic [5:0]   o_m_axis_tuser,   // [5:0] token_kind
    output logic         o_m_axis_tlast    // last_of_run
);
    import ssl_pkg::*;

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;
    logic [1:0]  r_cnt;
    t_token      r_slot0, r_slot1;

    logic        pop, room, fire;
    t_scan       scan;

    assign pop  = (r_cnt != 2'd0) && i_m_axis_tready;
    // both token slots must be free, or the last one draining now, before a byte is scanned
    assign room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign fire = r_in_valid && room;

    assign o_s_axis_tready = !r_in_valid || fire;

    ssl_scanner u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_in_cmd),
        .i_byte  (r_in_byte),
        .o_scan  (scan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (fire) begin
            r_cnt <= scan.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_slot0 <= scan.tok0;
            r_slot1 <= scan.tok1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {r_slot0.len, r_slot0.start, r_slot0.value};
    assign o_m_axis_tuser  = r_slot0.kind;
    assign o_m_axis_tlast  = r_slot0.last;

endmodule

// ===== rtl/ssl_checker.sv =====
// ----------------------------------------------------------------------------
// ssl_checker
// Port-level checks for the script source lexer, bound to the top level.
// ----------------------------------------------------------------------------
module ssl_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [79:0]  o_m_axis_tdata,
    input logic [5:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);
    import ssl_pkg::*;

    // stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("token changed while stalled");

    // EOF closes the run, with zero value and length
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == K_EOF) |->
            o_m_axis_tlast && (o_m_axis_tdata[79:56] == 24'd0)
            && (o_m_axis_tdata[31:0] == 32'd0))
        else $error("malformed EOF token");

    // error tokens cover one byte
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == K_ERR) |->
            (o_m_axis_tdata[79:56] == 24'd1) && (o_m_axis_tdata[31:8] == 24'd0))
        else $error("malformed error token");

    // nothing leaves the block right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("token valid after reset");

endmodule

bind script_source_lexer ssl_checker u_ssl_checker (.*);
